FILE: src/ntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int RES_W = 20;
	localparam int BETA_W = 14;
	localparam int SAMPLE_W = 12;
	localparam int TEMP_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SERIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd2;

	localparam logic [RES_W-1:0] SERIES_RST = 20'd10000;
	localparam logic [RES_W-1:0] NOMINAL_RST = 20'd10000;
	localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [63:0] SCALE_Q40 = 64'd100 << 40;
	localparam logic [63:0] T25_HUNDREDTHS = 64'd29815;
	localparam logic [63:0] INV25_Q40 = (SCALE_Q40 + T25_HUNDREDTHS / 64'd2) / T25_HUNDREDTHS;

	// kelvin hundredths at the clamp limits
	localparam logic [15:0] Q_LOW = 16'd23315;
	localparam logic [15:0] Q_HIGH = 16'd39315;
	localparam logic [15:0] Q_BIAS = 16'd23310;
	localparam logic [12:0] RECIP_10 = 13'd6554;

	localparam logic [TEMP_W-1:0] TEMP_MIN = 12'hE70;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 12'd1200;
	localparam logic [TEMP_W-1:0] TEMP_OFS = 12'd400;

	// log2(1 + i/16) in q16
	function automatic logic [16:0] log2_tab(input logic [4:0] i);
		logic [16:0] v;
		begin
			case (i)
				5'd0: v = 17'd0;
				5'd1: v = 17'd5732;
				5'd2: v = 17'd11136;
				5'd3: v = 17'd16248;
				5'd4: v = 17'd21098;
				5'd5: v = 17'd25711;
				5'd6: v = 17'd30109;
				5'd7: v = 17'd34312;
				5'd8: v = 17'd38336;
				5'd9: v = 17'd42196;
				5'd10: v = 17'd45904;
				5'd11: v = 17'd49472;
				5'd12: v = 17'd52911;
				5'd13: v = 17'd56229;
				5'd14: v = 17'd59434;
				5'd15: v = 17'd62534;
				5'd16: v = 17'd65536;
				default: v = 17'd0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/ntc_log2.sv
`timescale 1ns / 1ps
`default_nettype none
module ntc_log2 import ntc_pkg::*; #(
	parameter int XW = 32,
	parameter int LW = 22
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [XW-1:0] x,
	output logic [LW-1:0] log2_val
);

	localparam int PW = $clog2(XW);

	logic [PW-1:0] p;
	logic [PW-1:0] sh;
	logic [XW-1:0] xn;
	logic [PW-1:0] p_s1;
	logic [15:0] r_s1;
	logic [16:0] a0;
	logic [16:0] a1;
	logic [28:0] prod;
	logic [PW-1:0] p_s2;
	logic [16:0] a0_s2;
	logic [28:0] prod_s2;
	logic [28:0] rnd;
	logic [LW-1:0] l_s3;

	always_comb begin
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				p = PW'(i);
			end
		end
		sh = PW'(XW - 1) - p;
		xn = x << sh;
	end

	always_comb begin
		a0 = log2_tab({1'b0, r_s1[15:12]});
		a1 = log2_tab({1'b0, r_s1[15:12]} + 5'd1);
		prod = 29'(a1 - a0) * 29'(r_s1[11:0]);
		rnd = prod_s2 + 29'd2048;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			r_s1 <= xn[XW-2 -: 16];
			p_s2 <= p_s1;
			a0_s2 <= a0;
			prod_s2 <= prod;
			l_s3 <= (LW'(p_s2) << 16) + LW'(a0_s2) + LW'(rnd[28:12]);
		end
	end

	assign log2_val = l_s3;

endmodule
`default_nettype wire

FILE: src/ntc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ntc_div import ntc_pkg::*; #(
	parameter int DW = 46,
	parameter int VW = 14,
	parameter int TW = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic [DW-1:0] in_num,
	input wire logic [VW-1:0] in_den,
	input wire logic [TW-1:0] in_tag,
	output logic out_valid,
	output logic [DW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);

	logic vld_s [DW+1];
	logic [DW-1:0] num_s [DW+1];
	logic [DW-1:0] quo_s [DW+1];
	logic [VW-1:0] rem_s [DW+1];
	logic [VW-1:0] den_s [DW+1];
	logic [TW-1:0] tag_s [DW+1];

	assign vld_s[0] = in_valid;
	assign num_s[0] = in_num;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic ge;

		always_comb begin
			trial = {rem_s[k], num_s[k][DW-1]};
			diff = trial - {1'b0, den_s[k]};
			ge = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= num_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][DW-2:0], ge};
				rem_s[k+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = vld_s[DW];
	assign out_quo = quo_s[DW];
	assign out_tag = tag_s[DW];

endmodule
`default_nettype wire

FILE: src/ntc_adc_to_temperature.sv
// throughput: one sample per cycle while the output is not stalled,
// set by the bit-per-stage pipelined dividers
// the whole pipeline holds while a result waits at the output
// arst_n clears all valid bits and loads the default series, nominal and beta values
`timescale 1ns / 1ps
`default_nettype none
module ntc_adc_to_temperature import ntc_pkg::*; #(
	parameter int ADC_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata, // adc_sample
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [15:0] m_tdata, // temperature_tenths, clamped
	input wire logic cfg_wen,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int NW = RES_W + ADC_BITS;
	localparam int LW = $clog2(NW + 1) + 16;
	localparam int D1 = LW + 24;
	localparam int DDW = (D1 > 32 ? D1 : 32) + 1;
	localparam int D2W = (DDW > 47 ? DDW : 47) + 1;
	localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

	logic [RES_W-1:0] series_q;
	logic [RES_W-1:0] nominal_q;
	logic [BETA_W-1:0] beta_q;

	logic en;
	logic [ADC_BITS-1:0] a;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s8;
	logic frc_s1, frc_s2, frc_s3, frc_s4, frc_s5, frc_s6, frc_s8;
	logic [NW-1:0] num_s1;
	logic [NW-1:0] den_s1;
	logic [LW-1:0] lg_num;
	logic [LW-1:0] lg_den;
	logic [LW:0] ldiff;
	logic neg_s5, neg_s6, neg_s8;
	logic [LW-1:0] lmag_s5;
	logic [LW+30:0] lnp_s6;
	logic [D1-1:0] dvd1;

	logic div1_vld;
	logic [D1-1:0] term;
	logic [1:0] div1_tag;
	logic [DDW:0] dsum;
	logic lo_s8, hi_s8;
	logic [DDW-1:0] dmag_s8;
	logic [D2W-1:0] dvd2;

	logic div2_vld;
	logic [D2W-1:0] quo;
	logic [1:0] div2_tag;
	logic [13:0] xb;
	logic [26:0] xprod;
	logic [TEMP_W-1:0] temp;
	logic clamp;

	logic m_tvalid_q;
	logic [TEMP_W-1:0] temp_q;
	logic clamp_q;

	assign en = !m_tvalid_q || m_tready;
	assign s_tready = en;

	if (ADC_BITS <= SAMPLE_W) begin : g_narrow
		assign a = s_tdata[ADC_BITS-1:0];
	end else begin : g_wide
		assign a = {{(ADC_BITS-SAMPLE_W){1'b0}}, s_tdata[SAMPLE_W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SERIES_RST;
			nominal_q <= NOMINAL_RST;
			beta_q <= BETA_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_SERIES: series_q <= cfg_wdata[RES_W-1:0];
				REG_NOMINAL: nominal_q <= cfg_wdata[RES_W-1:0];
				REG_BETA: beta_q <= cfg_wdata[BETA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s8 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s8 <= div1_vld;
			m_tvalid_q <= div2_vld;
		end
	end

	// resistance terms, out-of-range samples and zero configuration values
	always_ff @(posedge clk) begin
		if (en) begin
			frc_s1 <= (a >= FULL) || (a == '0) || (series_q == '0) ||
				(nominal_q == '0) || (beta_q == '0);
			num_s1 <= NW'(series_q) * NW'(FULL - a);
			den_s1 <= NW'(nominal_q) * NW'(a);
			frc_s2 <= frc_s1;
			frc_s3 <= frc_s2;
			frc_s4 <= frc_s3;
		end
	end

	ntc_log2 #(.XW(NW), .LW(LW)) u_log_num (
		.clk(clk), .en(en), .x(num_s1), .log2_val(lg_num)
	);

	ntc_log2 #(.XW(NW), .LW(LW)) u_log_den (
		.clk(clk), .en(en), .x(den_s1), .log2_val(lg_den)
	);

	assign ldiff = {1'b0, lg_num} - {1'b0, lg_den};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s5 <= ldiff[LW];
			lmag_s5 <= ldiff[LW] ? LW'(-ldiff) : ldiff[LW-1:0];
			frc_s5 <= frc_s4;
			lnp_s6 <= (LW+31)'(lmag_s5) * (LW+31)'(LN2_Q30) + ((LW+31)'(1) << 29);
			neg_s6 <= neg_s5;
			frc_s6 <= frc_s5;
		end
	end

	// ln in q16 shifted up to q40, rounded for the beta divide
	assign dvd1 = {lnp_s6[LW+29:30], 24'd0} + D1'(beta_q >> 1);

	ntc_div #(.DW(D1), .VW(BETA_W), .TW(2)) u_div_beta (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s6), .in_num(dvd1), .in_den(beta_q), .in_tag({neg_s6, frc_s6}),
		.out_valid(div1_vld), .out_quo(term), .out_tag(div1_tag)
	);

	assign dsum = div1_tag[1] ? ((DDW+1)'(INV25_Q40) - (DDW+1)'(term)) :
		((DDW+1)'(INV25_Q40) + (DDW+1)'(term));

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s8 <= div1_tag[0];
			neg_s8 <= dsum[DDW];
			lo_s8 <= div1_tag[0] || dsum[DDW];
			hi_s8 <= !div1_tag[0] && !dsum[DDW] && (dsum == '0);
			dmag_s8 <= dsum[DDW-1:0];
		end
	end

	assign dvd2 = D2W'(SCALE_Q40) + D2W'(dmag_s8 >> 1);

	ntc_div #(.DW(D2W), .VW(DDW), .TW(2)) u_div_kelvin (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s8), .in_num(dvd2), .in_den(dmag_s8),
		.in_tag({hi_s8, lo_s8 || (frc_s8 && neg_s8)}),
		.out_valid(div2_vld), .out_quo(quo), .out_tag(div2_tag)
	);

	// kelvin hundredths to celsius tenths, rounded, with limits
	always_comb begin
		xb = 14'(quo[15:0] - Q_BIAS);
		xprod = 27'(xb) * 27'(RECIP_10);
		temp = TEMP_W'(xprod[26:16]) - TEMP_OFS;
		clamp = 1'b0;
		if (div2_tag[0]) begin
			temp = TEMP_MIN;
			clamp = 1'b1;
		end else if (div2_tag[1]) begin
			temp = TEMP_MAX;
			clamp = 1'b1;
		end else if (quo < D2W'(Q_LOW)) begin
			temp = TEMP_MIN;
			clamp = 1'b1;
		end else if (quo > D2W'(Q_HIGH)) begin
			temp = TEMP_MAX;
			clamp = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_q <= temp;
			clamp_q <= clamp;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {3'd0, clamp_q, temp_q};

endmodule
`default_nettype wire

FILE: src/ntc_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ntc_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [15:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [15:0] m_tdata
);

	logic unused_in;
	assign unused_in = s_tvalid ^ (^s_tdata);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while pipeline stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[12] |->
		$signed(m_tdata[11:0]) >= -12'sd400 && $signed(m_tdata[11:0]) <= 12'sd1200)
		else $error("unclamped result out of range");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[11:0] == 12'hE70 || m_tdata[11:0] == 12'd1200)
		else $error("clamped result not at a limit");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:13] == 3'd0)
		else $error("padding bits set");

endmodule

bind ntc_adc_to_temperature ntc_chk u_chk (.*);
`default_nettype wire

FILE: verif/ntc_adc_to_temperature_tb.sv
`timescale 1ns / 1ps
module ntc_adc_to_temperature_tb;
	import ntc_pkg::*;

	typedef struct packed {
		logic [TEMP_W-1:0] tenths;
		logic flag;
	} temp_result_t;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		bit typed;
		logic [TEMP_W-1:0] tenths;
		logic flag;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_SERIES;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic [RES_W-1:0] series_ohms = SERIES_RST;
	logic [RES_W-1:0] nominal_ohms = NOMINAL_RST;
	logic [BETA_W-1:0] beta_kelvin = BETA_RST;
	temp_result_t pending_temps[$];
	int mismatches = 0;
	bit no_idle = 1'b0;

	localparam longint unsigned ADC_FULL = 64'd4095;
	localparam longint unsigned LN2 = 64'd744261118;
	localparam longint unsigned Q40_100 = 64'd100 << 40;
	localparam int DRAIN_CYCLES = 150;

	ntc_adc_to_temperature uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint unsigned log2_q16(longint unsigned x);
		longint unsigned frac_tab[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
			34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
		longint unsigned f, r, lo, hi, t;
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (x[i]) p = i;
		f = (p >= 16) ? (x >> (p - 16)) : (x << (16 - p));
		r = f & 64'hFFFF;
		lo = frac_tab[r >> 12];
		hi = frac_tab[(r >> 12) + 1];
		t = r & 64'hFFF;
		return (longint'(p) << 16) + lo + (((hi - lo) * t + 2048) >> 12);
	endfunction

	function automatic temp_result_t convert_sample(logic [SAMPLE_W-1:0] sample);
		longint unsigned a, lmag, lnmag, term, inv25, q;
		longint l, d, h;
		temp_result_t res;
		a = 64'(sample);
		res.tenths = TEMP_MIN;
		res.flag = 1'b1;
		if (a >= ADC_FULL || a == 0 || series_ohms == 0 || nominal_ohms == 0 || beta_kelvin == 0)
			return res;
		l = longint'(log2_q16(longint'(series_ohms) * (ADC_FULL - a)))
			- longint'(log2_q16(longint'(nominal_ohms) * a));
		lmag = (l < 0) ? -l : l;
		lnmag = (lmag * LN2 + (64'd1 << 29)) >> 30;
		term = ((lnmag << 24) + (beta_kelvin >> 1)) / beta_kelvin;
		inv25 = (Q40_100 + 64'd29815 / 2) / 64'd29815;
		d = (l < 0) ? longint'(inv25) - longint'(term) : longint'(inv25) + longint'(term);
		if (d < 0)
			return res;
		if (d == 0) begin
			res.tenths = TEMP_MAX;
			return res;
		end
		q = (Q40_100 + (longint'(d) >> 1)) / longint'(d);
		h = longint'(q) - 27315;
		if (h < -4000)
			return res;
		if (h > 12000) begin
			res.tenths = TEMP_MAX;
			return res;
		end
		res.tenths = TEMP_W'((h + 4005) / 10 - 400);
		res.flag = 1'b0;
		return res;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_idx = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_SERIES: series_ohms = value;
			REG_NOMINAL: nominal_ohms = value;
			REG_BETA: beta_kelvin = value[BETA_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(sample_row_t row);
		int gap;
		temp_result_t res;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {4'b0, row.sample};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		res = convert_sample(row.sample);
		if (row.typed) begin
			res.tenths = row.tenths;
			res.flag = row.flag;
		end
		pending_temps.push_back(res);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_temps.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_W'($urandom_range(0, 3));
			1: return SAMPLE_W'($urandom_range(4090, 4095));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		temp_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.tenths = m_tdata[11:0];
			got.flag = m_tdata[12];
			if (pending_temps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: tdata %h", m_tdata);
			end else begin
				want = pending_temps.pop_front();
				if (got !== want || m_tdata[15:13] !== 3'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp temp %0d clamp %b, got temp %0d clamp %b (tdata %h)",
							$signed(want.tenths), want.flag, $signed(got.tenths), got.flag,
							m_tdata);
				end
			end
		end
	end

	initial begin
		sample_row_t directed[] = '{
			'{12'd0, 1'b1, TEMP_MIN, 1'b1},
			'{12'd4095, 1'b1, TEMP_MIN, 1'b1},
			'{12'd1, 1'b0, '0, 1'b0},
			'{12'd2, 1'b0, '0, 1'b0},
			'{12'd4094, 1'b0, '0, 1'b0},
			'{12'd4093, 1'b0, '0, 1'b0},
			'{12'd2048, 1'b0, '0, 1'b0},
			'{12'd2047, 1'b0, '0, 1'b0},
			'{12'd1000, 1'b0, '0, 1'b0},
			'{12'd3000, 1'b0, '0, 1'b0},
			'{12'd100, 1'b0, '0, 1'b0},
			'{12'd3500, 1'b0, '0, 1'b0},
			'{12'hAAA, 1'b0, '0, 1'b0},
			'{12'h555, 1'b0, '0, 1'b0},
			'{12'd4000, 1'b0, '0, 1'b0},
			'{12'd500, 1'b0, '0, 1'b0},
			'{12'd3900, 1'b0, '0, 1'b0},
			'{12'd300, 1'b0, '0, 1'b0}
		};
		logic [CFG_DATA_W-1:0] cfg_sets[][3] = '{
			'{20'd1, 20'hFFFFF, 20'd1000},
			'{20'hFFFFF, 20'd1, 20'h3FFF},
			'{20'd0, 20'd10000, 20'd3950},
			'{20'd10000, 20'd0, 20'd3950},
			'{20'd10000, 20'd10000, 20'd0},
			'{20'd1000000, 20'd1000000, 20'd10000},
			'{20'd4700, 20'd10000, 20'd3435}
		};
		sample_row_t row;
		int n;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_sample(directed[i]);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < cfg_sets.size()) begin
				write_reg(REG_SERIES, cfg_sets[ph][0]);
				write_reg(REG_NOMINAL, cfg_sets[ph][1]);
				write_reg(REG_BETA, cfg_sets[ph][2]);
			end else begin
				write_reg(REG_SERIES, CFG_DATA_W'($urandom_range(1, 1000000)));
				write_reg(REG_NOMINAL, CFG_DATA_W'($urandom_range(1, 1000000)));
				write_reg(REG_BETA, CFG_DATA_W'($urandom_range(1000, 10000)));
			end
			no_idle = (ph % 3 == 2);
			n = (ph < 5) ? 25 : 77;
			for (int k = 0; k < n; k++) begin
				row.sample = rand_sample();
				row.typed = 1'b0;
				row.tenths = '0;
				row.flag = 1'b0;
				send_sample(row);
			end
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
